// ===== design/swm_pkg.sv =====
// Shared constants and types for the sliding window maximum block.
// No dependencies.
`default_nettype none

package swm_pkg;

  // word widths fixed by the interface
  localparam int SAMPLE_W = 32;
  localparam int CFG_W    = 7;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  // default deque depth and register reset value
  localparam int          MAX_WINDOW_DEF  = 64;
  localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = CFG_W'(3);

  // register index, taken from the word address
  localparam logic REG_WINDOW_SIZE = 1'b0;

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FRONT = 3'b010,
    S_BACK  = 3'b100
  } state_e;

endpackage

`default_nettype wire

// ===== design/sliding_window_max.sv =====
// Sliding window maximum: monotonic deque kept in one synchronous RAM.
// An accepted word steps through S_FRONT, retiring each candidate that ages out, then,
// when candidates remain, through S_BACK, dropping each candidate not above it while
// another is left; each step costs one read on the single RAM read port.
// The result is registered and shows in the cycle after the push; a stalled one holds the push.
// Reset (rst_ni low, async) empties the deque and sets window_size to 3.
`default_nettype none

module sliding_window_max
  import swm_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // input stream
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  input  wire logic                       start_req_i,
  // result stream
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0]      window_max_o,
  // configuration
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [APB_AW-1:0]          paddr,
  input  wire logic [APB_DW-1:0]          pwdata,
  output logic [APB_DW-1:0]               prdata,
  output logic                            pready
);

  localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int PW   = $clog2(2 * MAX_WINDOW);
  localparam int CW   = $clog2(MAX_WINDOW + 1);
  localparam int WW   = (CW > CFG_W) ? CW : CFG_W;
  localparam int CMPW = ((PW + 1) > WW) ? (PW + 1) : WW;

  localparam logic [AW-1:0]  PTR_LAST = AW'(MAX_WINDOW - 1);
  localparam logic [PW-1:0]  POS_LAST = PW'(2 * MAX_WINDOW - 1);
  localparam logic [PW:0]    POS_MOD  = (PW + 1)'(2 * MAX_WINDOW);
  localparam logic [CW-1:0]  CNT_MAX  = CW'(MAX_WINDOW);
  localparam logic [WW-1:0]  WIN_MAX  = WW'(MAX_WINDOW);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic [PW-1:0]              pos;
  } entry_t;

  // registers
  state_e                     state_q, state_d;
  logic [AW-1:0]              front_q, front_d;
  logic [AW-1:0]              back_q, back_d;
  logic [CW-1:0]              count_q, count_d;
  logic [PW-1:0]              pos_q, pos_d;
  logic [CW-1:0]              fill_q, fill_d;
  logic signed [SAMPLE_W-1:0] sample_q, sample_d;
  logic signed [SAMPLE_W-1:0] front_val_q, front_val_d;
  logic                       out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] window_max_q, window_max_d;
  logic [CFG_W-1:0]           window_size_q;

  // deque RAM
  entry_t                     mem [MAX_WINDOW];
  entry_t                     rd_q;
  logic [AW-1:0]              rd_addr;
  logic                       mem_we;
  logic [AW-1:0]              wr_addr;

  // helpers
  logic [WW-1:0]   cfg_ext;
  logic [WW-1:0]   eff_w;
  logic [AW-1:0]   front_nxt, back_nxt, back_last, back_last2;
  logic [PW-1:0]   pos_nxt;
  logic [CW-1:0]   fill_inc;
  logic [PW:0]     age;
  logic            aged;
  logic            emit;
  logic            push_ok;
  logic            drop_back;

  // configuration port
  assign pready = 1'b1;
  assign prdata = APB_DW'(window_size_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WINDOW_SIZE_RST;
    end else if (psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE)) begin
      window_size_q <= pwdata[CFG_W-1:0];
    end
  end

  // clamp window size to 1..MAX_WINDOW
  assign cfg_ext = WW'(window_size_q);
  always_comb begin
    if (cfg_ext == '0) begin
      eff_w = WW'(1);
    end else if (cfg_ext > WIN_MAX) begin
      eff_w = WIN_MAX;
    end else begin
      eff_w = cfg_ext;
    end
  end

  // ring pointer and position arithmetic
  assign front_nxt  = (front_q == PTR_LAST) ? '0 : front_q + AW'(1);
  assign back_nxt   = (back_q == PTR_LAST) ? '0 : back_q + AW'(1);
  assign back_last  = (back_q == '0) ? PTR_LAST : back_q - AW'(1);
  assign back_last2 = (back_last == '0) ? PTR_LAST : back_last - AW'(1);
  assign pos_nxt    = (pos_q == POS_LAST) ? '0 : pos_q + PW'(1);
  assign fill_inc   = (fill_q == CNT_MAX) ? fill_q : fill_q + CW'(1);

  // age of the front candidate, modulo twice the depth
  always_comb begin
    if (pos_q >= rd_q.pos) begin
      age = {1'b0, pos_q} - {1'b0, rd_q.pos};
    end else begin
      age = {1'b0, pos_q} + POS_MOD - {1'b0, rd_q.pos};
    end
  end

  assign aged      = CMPW'(age) >= CMPW'(eff_w);
  assign emit      = CMPW'(fill_inc) >= CMPW'(eff_w);
  assign push_ok   = !out_valid_q || !out_stall_i;
  assign drop_back = rd_q.value <= sample_q;

  // sequencer
  always_comb begin
    state_d      = state_q;
    front_d      = front_q;
    back_d       = back_q;
    count_d      = count_q;
    pos_d        = pos_q;
    fill_d       = fill_q;
    sample_d     = sample_q;
    front_val_d  = front_val_q;
    window_max_d = window_max_q;
    out_valid_d  = out_valid_q && out_stall_i;
    rd_addr      = front_q;
    mem_we       = 1'b0;
    wr_addr      = back_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          sample_d = sample_i;
          state_d  = S_FRONT;
          if (start_req_i) begin
            front_d = '0;
            back_d  = '0;
            count_d = '0;
            pos_d   = '0;
            fill_d  = '0;
            rd_addr = '0;
          end
        end
      end

      // retire aged candidates at the front, or append the sample to an empty deque
      S_FRONT: begin
        if (count_q != '0) begin
          if (aged) begin
            front_d = front_nxt;
            count_d = count_q - CW'(1);
            rd_addr = front_nxt;
          end else begin
            front_val_d = rd_q.value;
            rd_addr     = back_last;
            state_d     = S_BACK;
          end
        end else if (push_ok) begin
          // empty deque: the sample is the only candidate
          mem_we  = 1'b1;
          wr_addr = back_q;
          back_d  = back_nxt;
          count_d = CW'(1);
          pos_d   = pos_nxt;
          fill_d  = fill_inc;
          state_d = S_IDLE;
          if (emit) begin
            out_valid_d  = 1'b1;
            window_max_d = sample_q;
          end
        end
      end

      // drop candidates not above the sample, then append
      S_BACK: begin
        rd_addr = back_last;
        if (drop_back && (count_q != CW'(1))) begin
          back_d  = back_last;
          count_d = count_q - CW'(1);
          rd_addr = back_last2;
        end else if (push_ok) begin
          mem_we  = 1'b1;
          pos_d   = pos_nxt;
          fill_d  = fill_inc;
          state_d = S_IDLE;
          if (drop_back) begin
            // last candidate dropped: sample replaces it
            wr_addr = back_last;
            back_d  = back_q;
            count_d = count_q;
          end else begin
            wr_addr = back_q;
            back_d  = back_nxt;
            count_d = count_q + CW'(1);
          end
          if (emit) begin
            out_valid_d  = 1'b1;
            window_max_d = drop_back ? sample_q : front_val_q;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      back_q      <= '0;
      count_q     <= '0;
      pos_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      back_q      <= back_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sample_q     <= sample_d;
    front_val_q  <= front_val_d;
    window_max_q <= window_max_d;
  end

  // deque RAM, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= '{value: sample_q, pos: pos_q};
    end
    rd_q <= mem[rd_addr];
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign window_max_o = window_max_q;

endmodule

`default_nettype wire
